@@ hdl/pli_pkg.sv @@
// Shared constants and types for the pixel lightness inverter.
// No dependencies; the interfaces and the top level in hdl/ import this package.
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int BYTE_W        = 8;
  localparam int CFG_ADDR_W    = 5;
  localparam int CFG_DATA_W    = 32;

  typedef logic [BYTE_W-1:0] pix_byte_t;

  // Register indexes (byte address is 4 * index)
  typedef enum logic [2:0] {
    REG_RED_SLOT   = 3'd0,
    REG_GREEN_SLOT = 3'd1,
    REG_BLUE_SLOT  = 3'd2,
    REG_ALPHA_SLOT = 3'd3,
    REG_UNPREMUL   = 3'd4
  } cfg_reg_t;

  localparam logic [1:0] RED_SLOT_RST   = 2'd2;
  localparam logic [1:0] GREEN_SLOT_RST = 2'd1;
  localparam logic [1:0] BLUE_SLOT_RST  = 2'd0;
  localparam logic [1:0] ALPHA_SLOT_RST = 2'd3;
  localparam logic       UNPREMUL_RST   = 1'b0;

  // Grey results below this level get inverted
  localparam pix_byte_t DARK_LIMIT = 8'd128;

endpackage

`default_nettype wire

@@ hdl/pli_in_if.sv @@
// Input channel: one pixel word (four bytes) with valid/ready.
// Depends on pli_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pli_in_if;
  import pli_pkg::*;

  logic      valid;
  logic      ready;
  pix_byte_t in_byte0;
  pix_byte_t in_byte1;
  pix_byte_t in_byte2;
  pix_byte_t in_byte3;

  modport source (output valid, output in_byte0, output in_byte1,
                  output in_byte2, output in_byte3, input ready);
  modport sink   (input valid, input in_byte0, input in_byte1,
                  input in_byte2, input in_byte3, output ready);
endinterface

`default_nettype wire

@@ hdl/pli_out_if.sv @@
// Output channel: one result pixel word (four bytes) with valid/ready.
// Depends on pli_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pli_out_if;
  import pli_pkg::*;

  logic      valid;
  logic      ready;
  pix_byte_t out_byte0;
  pix_byte_t out_byte1;
  pix_byte_t out_byte2;
  pix_byte_t out_byte3;

  modport source (output valid, output out_byte0, output out_byte1,
                  output out_byte2, output out_byte3, input ready);
  modport sink   (input valid, input out_byte0, input out_byte1,
                  input out_byte2, input out_byte3, output ready);
endinterface

`default_nettype wire

@@ hdl/pli_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Carries a valid bit and a sideband vector alongside. No package needed.
`timescale 1ns / 1ps
`default_nettype none

module pli_div #(
  parameter int LANES = 1,
  parameter int DW    = 8,   // divisor / remainder width
  parameter int QW    = 8,   // quotient bits = pipeline depth
  parameter int SW    = 1    // sideband width
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_vld,
  input  wire logic [LANES-1:0][DW-1:0]     in_hi,   // must be below in_den
  input  wire logic [LANES-1:0][QW-1:0]     in_lo,
  input  wire logic [LANES-1:0][DW-1:0]     in_den,
  input  wire logic [SW-1:0]                in_side,
  output logic                              out_vld,
  output logic      [LANES-1:0][QW-1:0]     out_quo,
  output logic      [SW-1:0]                out_side
);

  logic [QW-1:0]                  vld_q;
  logic [LANES-1:0][DW-1:0]       rem_q  [QW];
  logic [LANES-1:0][DW-1:0]       den_q  [QW];
  logic [LANES-1:0][QW-1:0]       lo_q   [QW];
  logic [LANES-1:0][QW-1:0]       quo_q  [QW];
  logic [SW-1:0]                  side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                     vld_p;
    logic [LANES-1:0][DW-1:0] rem_p;
    logic [LANES-1:0][DW-1:0] den_p;
    logic [LANES-1:0][QW-1:0] lo_p;
    logic [LANES-1:0][QW-1:0] quo_p;
    logic [SW-1:0]            side_p;
    logic [LANES-1:0][DW:0]   trial;
    logic [LANES-1:0][DW:0]   diff;
    logic [LANES-1:0]         ge;
    logic [LANES-1:0][DW-1:0] rem_next;
    logic [LANES-1:0][QW-1:0] lo_next;
    logic [LANES-1:0][QW-1:0] quo_next;

    if (k == 0) begin : g_first
      assign vld_p  = in_vld;
      assign rem_p  = in_hi;
      assign den_p  = in_den;
      assign lo_p   = in_lo;
      assign quo_p  = '0;
      assign side_p = in_side;
    end else begin : g_next
      assign vld_p  = vld_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign den_p  = den_q[k-1];
      assign lo_p   = lo_q[k-1];
      assign quo_p  = quo_q[k-1];
      assign side_p = side_q[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
      for (int j = 0; j < LANES; j++) begin
        trial[j]    = {rem_p[j], lo_p[j][QW-1]};
        diff[j]     = trial[j] - {1'b0, den_p[j]};
        ge[j]       = (trial[j] >= {1'b0, den_p[j]});
        rem_next[j] = ge[j] ? diff[j][DW-1:0] : trial[j][DW-1:0];
        lo_next[j]  = {lo_p[j][QW-2:0], 1'b0};
        quo_next[j] = {quo_p[j][QW-2:0], ge[j]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= rem_next;
        den_q[k]  <= den_p;
        lo_q[k]   <= lo_next;
        quo_q[k]  <= quo_next;
        side_q[k] <= side_p;
      end
    end
  end

  assign out_vld  = vld_q[QW-1];
  assign out_quo  = quo_q[QW-1];
  assign out_side = side_q[QW-1];

endmodule

`default_nettype wire

@@ hdl/pixel_luminosity_inverter_unit.sv @@
// Top level of the pixel lightness inverter: config registers and datapath.
// Depends on pli_pkg, pli_in_if, pli_out_if and pli_div.
//
//   channel   dir   handshake            payload
//   pix_in    in    valid / ready        in_byte0..3  (blue, green, red, alpha)
//   pix_out   out   valid / ready        out_byte0..3 (slot-mapped result)
//   apb       in    psel/penable/pready  paddr, pwdata, prdata (5 registers)
//
// One word enters per clock while the pipeline is not held (see below); most
// of the depth comes from the two restoring dividers (8 stages for the
// un-premultiply, FRAC_BITS + 1 for saturation and hue).
// rst is synchronous and clears every valid bit and the config registers.
// When the output register holds a word that is not taken, the whole
// pipeline holds; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module pixel_luminosity_inverter_unit #(
  parameter int FRAC_BITS = pli_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  pli_in_if.sink                                 pix_in,
  pli_out_if.source                              pix_out,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pli_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [pli_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [pli_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                   pready
);
  import pli_pkg::*;

  // ---------------------------------------------------------------------
  // Fixed-point constants. Fractions in [0,1] carry F fraction bits and
  // one integer bit so that 1.0 itself fits.
  // ---------------------------------------------------------------------
  localparam int F     = FRAC_BITS;
  localparam int W     = F + 1;
  localparam int HW    = F + 3;          // hue sum, below 6.0
  localparam int ONE   = 1 << F;
  localparam int HALF  = ONE / 2;
  localparam int SIXTH = ONE / 6;
  localparam int THIRD = ONE / 3;
  localparam int TWO_THIRDS = (2 * ONE) / 3;
  // c * 2^F / 255 = c * FK + c * FREM / 255
  localparam int FK    = ONE / 255;
  localparam int FREM  = ONE % 255;
  // x / 3 = (x * M3) >> (F + 3) exactly for x < 2^(F+2)
  localparam int M3    = ((1 << (F + 3)) + 2) / 3;

  localparam logic [W-1:0] ONE_C   = W'(ONE);
  localparam logic [W-1:0] HALF_C  = W'(HALF);
  localparam logic [W-1:0] SIXTH_C = W'(SIXTH);
  localparam logic [W-1:0] THIRD_C = W'(THIRD);
  localparam logic [W-1:0] TT_C    = W'(TWO_THIRDS);

  typedef enum logic [1:0] {SEXT_R, SEXT_G, SEXT_B} sext_t;
  typedef enum logic [1:0] {SEG_RISE, SEG_HIGH, SEG_FALL, SEG_LOW} seg_t;

  typedef logic [3:0][BYTE_W-1:0] pix_word_t;   // index = byte position

  // channel byte to fraction, truncated
  function automatic logic [W-1:0] to_frac(input pix_byte_t c);
    logic [15:0]  y;
    logic [7:0]   q1;
    logic [15:0]  r16;
    logic [7:0]   qy;
    logic [F+8:0] base;
    y    = 16'(c) * 16'(FREM);
    q1   = y[15:8];
    r16  = y - {q1, 8'b0} + 16'(q1);
    qy   = q1 + 8'(r16[9:0] >= 10'd255);
    base = (F+9)'(c) * (F+9)'(FK);
    return W'(base + (F+9)'(qy));
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [1:0] red_slot, green_slot, blue_slot, alpha_slot;
  logic       unpremul_en;
  logic       cfg_wr;
  cfg_reg_t   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      red_slot    <= RED_SLOT_RST;
      green_slot  <= GREEN_SLOT_RST;
      blue_slot   <= BLUE_SLOT_RST;
      alpha_slot  <= ALPHA_SLOT_RST;
      unpremul_en <= UNPREMUL_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_RED_SLOT:   red_slot    <= pwdata[1:0];
        REG_GREEN_SLOT: green_slot  <= pwdata[1:0];
        REG_BLUE_SLOT:  blue_slot   <= pwdata[1:0];
        REG_ALPHA_SLOT: alpha_slot  <= pwdata[1:0];
        REG_UNPREMUL:   unpremul_en <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_RED_SLOT:   prdata = CFG_DATA_W'(red_slot);
      REG_GREEN_SLOT: prdata = CFG_DATA_W'(green_slot);
      REG_BLUE_SLOT:  prdata = CFG_DATA_W'(blue_slot);
      REG_ALPHA_SLOT: prdata = CFG_DATA_W'(alpha_slot);
      REG_UNPREMUL:   prdata = CFG_DATA_W'(unpremul_en);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Global advance: every stage moves when the output register is free.
  // ---------------------------------------------------------------------
  logic o_vld;
  logic adv;

  assign adv          = !o_vld || pix_out.ready;
  assign pix_in.ready = adv;

  // ---------------------------------------------------------------------
  // Stage A: capture the input word
  // ---------------------------------------------------------------------
  logic      a_vld;
  pix_byte_t a_b, a_g, a_r, a_al;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_b  <= pix_in.in_byte0;
      a_g  <= pix_in.in_byte1;
      a_r  <= pix_in.in_byte2;
      a_al <= pix_in.in_byte3;
    end
  end

  // Un-premultiply: c*255/a. A channel at or above alpha saturates to 255,
  // so only channels below alpha go through the divider (quotient < 255).
  logic [2:0][BYTE_W-1:0] a_ch;
  logic [2:0]             a_sat, a_use;
  logic [2:0][7:0]        up_hi, up_lo, up_den;
  logic                   a_div_on;
  logic [15:0]            a_prod [3];

  assign a_ch     = {a_r, a_g, a_b};
  assign a_div_on = unpremul_en && (a_al != '0);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      a_sat[j]  = a_div_on && (a_ch[j] >= a_al);
      a_use[j]  = a_div_on && (a_ch[j] < a_al);
      a_prod[j] = {a_ch[j], 8'b0} - {8'b0, a_ch[j]};
      up_hi[j]  = a_use[j] ? a_prod[j][15:8] : 8'b0;
      up_lo[j]  = a_prod[j][7:0];
      up_den[j] = a_al;
    end
  end

  localparam int SW1 = 32 + 6;

  logic                  up_vld;
  logic [2:0][7:0]       up_quo;
  logic [SW1-1:0]        up_side;
  pix_word_t             up_orig;
  logic [2:0]            up_sat, up_use;

  pli_div #(
    .LANES (3),
    .DW    (8),
    .QW    (8),
    .SW    (SW1)
  ) u_unpremul_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (a_vld),
    .in_hi    (up_hi),
    .in_lo    (up_lo),
    .in_den   (up_den),
    .in_side  ({a_al, a_r, a_g, a_b, a_sat, a_use}),
    .out_vld  (up_vld),
    .out_quo  (up_quo),
    .out_side (up_side)
  );

  assign {up_orig, up_sat, up_use} = up_side;

  // ---------------------------------------------------------------------
  // Stage C: pick max, min and the hue difference pair
  // ---------------------------------------------------------------------
  logic [2:0][BYTE_W-1:0] up_ch;
  pix_byte_t              cm_mx, cm_mn, cm_x, cm_y;
  sext_t                  cm_sel;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      up_ch[j] = up_sat[j] ? 8'hFF : (up_use[j] ? up_quo[j] : up_orig[j]);
    end
    cm_mx = (up_ch[2] > up_ch[1]) ? up_ch[2] : up_ch[1];
    if (up_ch[0] > cm_mx) cm_mx = up_ch[0];
    cm_mn = (up_ch[2] < up_ch[1]) ? up_ch[2] : up_ch[1];
    if (up_ch[0] < cm_mn) cm_mn = up_ch[0];
    if (up_ch[2] == cm_mx) begin
      cm_sel = SEXT_R;
      cm_x   = up_ch[1];
      cm_y   = up_ch[0];
    end else if (up_ch[1] == cm_mx) begin
      cm_sel = SEXT_G;
      cm_x   = up_ch[0];
      cm_y   = up_ch[2];
    end else begin
      cm_sel = SEXT_B;
      cm_x   = up_ch[2];
      cm_y   = up_ch[1];
    end
  end

  logic      c_vld;
  pix_byte_t c_mx, c_mn, c_x, c_y;
  sext_t     c_sel;
  pix_word_t c_orig;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (adv) begin
      c_vld <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_mx   <= cm_mx;
      c_mn   <= cm_mn;
      c_x    <= cm_x;
      c_y    <= cm_y;
      c_sel  <= cm_sel;
      c_orig <= up_orig;
    end
  end

  // ---------------------------------------------------------------------
  // Stage D: convert to fractions
  // ---------------------------------------------------------------------
  logic         d_vld;
  logic [W-1:0] d_maxf, d_minf, d_xf, d_yf;
  logic         d_grey, d_neg;
  sext_t        d_sel;
  pix_word_t    d_orig;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (adv) begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_maxf <= to_frac(c_mx);
      d_minf <= to_frac(c_mn);
      d_xf   <= to_frac(c_x);
      d_yf   <= to_frac(c_y);
      d_grey <= (c_mx == c_mn);
      d_neg  <= (c_x < c_y);     // fraction order follows byte order
      d_sel  <= c_sel;
      d_orig <= c_orig;
    end
  end

  // Lightness, saturation denominator and hue numerator feed the divider.
  logic [W-1:0] dd, dl, dden, dad;
  logic [W:0]   dsum, dden_wide;
  logic [1:0][W-1:0] hs_hi, hs_lo, hs_den;

  always_comb begin
    dd        = d_maxf - d_minf;
    dsum      = {1'b0, d_maxf} + {1'b0, d_minf};
    dl        = dsum[W:1];
    dden_wide = (dl > HALF_C) ? ((W+1)'(2 * ONE) - dsum) : dsum;
    dden      = dden_wide[W-1:0];
    dad       = d_neg ? (d_yf - d_xf) : (d_xf - d_yf);
    hs_hi[0]  = {1'b0, dd[W-1:1]};
    hs_lo[0]  = {dd[0], F'(0)};
    hs_den[0] = dden;
    hs_hi[1]  = {1'b0, dad[W-1:1]};
    hs_lo[1]  = {dad[0], F'(0)};
    hs_den[1] = dd;
  end

  localparam int SW2 = W + 4 + 32;

  logic              hs_vld;
  logic [1:0][W-1:0] hs_quo;
  logic [SW2-1:0]    hs_side;
  logic [W-1:0]      hs_l;
  logic              hs_grey, hs_neg;
  logic [1:0]        hs_sel;
  pix_word_t         hs_orig;

  pli_div #(
    .LANES (2),
    .DW    (W),
    .QW    (W),
    .SW    (SW2)
  ) u_hsl_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (d_vld),
    .in_hi    (hs_hi),
    .in_lo    (hs_lo),
    .in_den   (hs_den),
    .in_side  ({dl, d_grey, d_neg, d_sel, d_orig}),
    .out_vld  (hs_vld),
    .out_quo  (hs_quo),
    .out_side (hs_side)
  );

  assign {hs_l, hs_grey, hs_neg, hs_sel, hs_orig} = hs_side;

  // ---------------------------------------------------------------------
  // Stage G: hue sum and the q product
  // ---------------------------------------------------------------------
  logic [W-1:0]  gm_nl, gm_s, gm_rq;
  logic          gm_lowl;
  logic [W:0]    gm_fac;
  logic [HW-1:0] gm_h;

  always_comb begin
    gm_s    = hs_quo[0];
    gm_rq   = hs_quo[1];
    gm_nl   = ONE_C - hs_l;
    gm_lowl = (gm_nl < HALF_C);
    gm_fac  = gm_lowl ? ((W+1)'(ONE) + (W+1)'(gm_s)) : (W+1)'(gm_s);
    case (sext_t'(hs_sel))
      SEXT_R:  gm_h = hs_neg ? (HW'(6 * ONE) - HW'(gm_rq)) : HW'(gm_rq);
      SEXT_G:  gm_h = hs_neg ? (HW'(2 * ONE) - HW'(gm_rq)) : (HW'(2 * ONE) + HW'(gm_rq));
      SEXT_B:  gm_h = hs_neg ? (HW'(4 * ONE) - HW'(gm_rq)) : (HW'(4 * ONE) + HW'(gm_rq));
      default: gm_h = '0;
    endcase
  end

  logic            g_vld;
  logic [HW-1:0]   g_h;
  logic [2*W:0]    g_pr;
  logic [W-1:0]    g_nl, g_s;
  logic            g_lowl, g_grey;
  pix_word_t       g_orig;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (adv) begin
      g_vld <= hs_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_h    <= gm_h;
      g_pr   <= (2*W+1)'(gm_nl) * (2*W+1)'(gm_fac);
      g_nl   <= gm_nl;
      g_s    <= gm_s;
      g_lowl <= gm_lowl;
      g_grey <= hs_grey || (gm_s == '0);   // zero saturation reads as grey
      g_orig <= hs_orig;
    end
  end

  // ---------------------------------------------------------------------
  // Stage H: hue / 6 product, q and p with clamps
  // ---------------------------------------------------------------------
  logic [W:0]   hm_prh, hm_q;
  logic [W+1:0] hm_p, hm_qx;
  logic [W-1:0] hm_qc, hm_pc;

  always_comb begin
    hm_prh = g_pr[F +: W+1];
    hm_q   = g_lowl ? hm_prh : ((W+1)'(g_nl) + (W+1)'(g_s) - hm_prh);
    hm_p   = (W+2)'({g_nl, 1'b0}) - (W+2)'(hm_q);
    hm_qc  = (hm_q > (W+1)'(ONE)) ? ONE_C : hm_q[W-1:0];
    hm_qx  = (W+2)'(hm_qc);
    if (hm_p[W+1]) begin
      hm_pc = '0;
    end else if (hm_p > hm_qx) begin
      hm_pc = hm_qc;
    end else begin
      hm_pc = hm_p[W-1:0];
    end
  end

  logic             h_vld;
  logic [2*F+3:0]   h_hm;
  logic [W-1:0]     h_q, h_p, h_nl;
  logic             h_grey;
  pix_word_t        h_orig;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else if (adv) begin
      h_vld <= g_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_hm   <= (2*F+4)'(g_h[HW-1:1]) * (2*F+4)'(M3);
      h_q    <= hm_qc;
      h_p    <= hm_pc;
      h_nl   <= g_nl;
      h_grey <= g_grey;
      h_orig <= g_orig;
    end
  end

  // ---------------------------------------------------------------------
  // Stage I: hue offsets per channel, segment and ramp factor
  // ---------------------------------------------------------------------
  logic [W-1:0]       im_hue;
  logic [W:0]         im_tr;
  logic [2:0][W-1:0]  im_t, im_u;
  logic [W+2:0]       im_six;
  seg_t               im_seg [3];

  always_comb begin
    im_hue  = h_hm[F+3 +: W];
    im_tr   = (W+1)'(im_hue) + (W+1)'(THIRD_C);
    im_t[2] = (im_tr > (W+1)'(ONE)) ? W'(im_tr - (W+1)'(ONE)) : im_tr[W-1:0];
    im_t[1] = im_hue;
    im_t[0] = (im_hue >= THIRD_C) ? (im_hue - THIRD_C) : (im_hue + ONE_C - THIRD_C);
    im_six  = '0;
    for (int j = 0; j < 3; j++) begin
      if (im_t[j] < SIXTH_C) begin
        im_seg[j] = SEG_RISE;
        im_six    = (W+3)'({im_t[j], 2'b0}) + (W+3)'({im_t[j], 1'b0});
      end else if (im_t[j] < HALF_C) begin
        im_seg[j] = SEG_HIGH;
        im_six    = '0;
      end else if (im_t[j] < TT_C) begin
        im_seg[j] = SEG_FALL;
        im_six    = (W+3)'({TT_C - im_t[j], 2'b0}) + (W+3)'({TT_C - im_t[j], 1'b0});
      end else begin
        im_seg[j] = SEG_LOW;
        im_six    = '0;
      end
      im_u[j] = im_six[W-1:0];
    end
  end

  logic              i_vld;
  seg_t              i_seg [3];
  logic [2:0][W-1:0] i_u;
  logic [W-1:0]      i_q, i_p, i_nl;
  logic              i_grey;
  pix_word_t         i_orig;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_vld <= 1'b0;
    end else if (adv) begin
      i_vld <= h_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_seg  <= im_seg;
      i_u    <= im_u;
      i_q    <= h_q;
      i_p    <= h_p;
      i_nl   <= h_nl;
      i_grey <= h_grey;
      i_orig <= h_orig;
    end
  end

  // ---------------------------------------------------------------------
  // Stage J: ramp products (q-p)*u >> F
  // ---------------------------------------------------------------------
  logic [W-1:0]       jm_span;
  logic [2*W-1:0]     jm_prod [3];

  always_comb begin
    jm_span = i_q - i_p;
    for (int j = 0; j < 3; j++) begin
      jm_prod[j] = (2*W)'(jm_span) * (2*W)'(i_u[j]);
    end
  end

  logic              j_vld;
  seg_t              j_seg [3];
  logic [2:0][W-1:0] j_ph;
  logic [W-1:0]      j_q, j_p, j_nl;
  logic              j_grey;
  pix_word_t         j_orig;

  always_ff @(posedge clk) begin
    if (rst) begin
      j_vld <= 1'b0;
    end else if (adv) begin
      j_vld <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        j_ph[j] <= jm_prod[j][F +: W];
      end
      j_seg  <= i_seg;
      j_q    <= i_q;
      j_p    <= i_p;
      j_nl   <= i_nl;
      j_grey <= i_grey;
      j_orig <= i_orig;
    end
  end

  // ---------------------------------------------------------------------
  // Stage K: channel fraction by segment, or 1-L for grey
  // ---------------------------------------------------------------------
  logic [2:0][W-1:0] km_v;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (j_grey) begin
        km_v[j] = j_nl;
      end else begin
        case (j_seg[j])
          SEG_RISE: km_v[j] = j_p + j_ph[j];
          SEG_HIGH: km_v[j] = j_q;
          SEG_FALL: km_v[j] = j_p + j_ph[j];
          SEG_LOW:  km_v[j] = j_p;
          default:  km_v[j] = j_p;
        endcase
      end
    end
  end

  logic              k_vld;
  logic [2:0][W-1:0] k_v;
  pix_word_t         k_orig;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_vld <= 1'b0;
    end else if (adv) begin
      k_vld <= j_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_v    <= km_v;
      k_orig <= j_orig;
    end
  end

  // ---------------------------------------------------------------------
  // Stage L: fraction to byte, (v*255) >> F
  // ---------------------------------------------------------------------
  logic [W+7:0] lm_scaled [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lm_scaled[j] = {k_v[j], 8'b0} - (W+8)'(k_v[j]);
    end
  end

  logic                   l_vld;
  logic [2:0][BYTE_W-1:0] l_ch;
  pix_word_t              l_orig;

  always_ff @(posedge clk) begin
    if (rst) begin
      l_vld <= 1'b0;
    end else if (adv) begin
      l_vld <= k_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        l_ch[j] <= lm_scaled[j][F +: 8];
      end
      l_orig <= k_orig;
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: invert dark grey, then place bytes by slot. Alpha goes
  // first, then red, green, blue, so a later channel wins a shared slot.
  // ---------------------------------------------------------------------
  logic                   om_dark;
  logic [2:0][BYTE_W-1:0] om_ch;
  pix_word_t              om_res;

  always_comb begin
    om_dark = (l_ch[0] == l_ch[1]) && (l_ch[0] == l_ch[2]) && (l_ch[0] < DARK_LIMIT);
    for (int j = 0; j < 3; j++) begin
      om_ch[j] = om_dark ? ~l_ch[j] : l_ch[j];
    end
    om_res             = l_orig;
    om_res[alpha_slot] = l_orig[3];
    om_res[red_slot]   = om_ch[2];
    om_res[green_slot] = om_ch[1];
    om_res[blue_slot]  = om_ch[0];
  end

  pix_word_t o_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (adv) begin
      o_vld <= l_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_res <= om_res;
    end
  end

  assign pix_out.valid     = o_vld;
  assign pix_out.out_byte0 = o_res[0];
  assign pix_out.out_byte1 = o_res[1];
  assign pix_out.out_byte2 = o_res[2];
  assign pix_out.out_byte3 = o_res[3];

endmodule

`default_nettype wire

@@ tb/sv/pixel_luminosity_inverter_unit_test.sv @@
// Self-checking bench for pixel_luminosity_inverter_unit: directed table plus random
// pixels, checked against a fixed-point lightness inversion predictor.
// Depends on pli_pkg, pli_in_if, pli_out_if and the block itself.
`timescale 1ns / 1ps

module pixel_luminosity_inverter_unit_test;
  import pli_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;
  localparam longint HALF = ONE / 2;
  localparam longint SIXTH = ONE / 6;
  localparam longint THIRD = ONE / 3;
  localparam longint TWO_THIRDS = (2 * ONE) / 3;
  localparam int LATENCY = FB + 19;

  typedef struct packed {
    pix_byte_t b3, b2, b1, b0;
  } pixel_t;

  typedef struct {
    pixel_t pix;
    bit     fixed;   // expected word typed into the table
    pixel_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  pli_in_if  pix_in();
  pli_out_if pix_out();

  pixel_luminosity_inverter_unit dut (
    .clk(clk), .rst(rst), .pix_in(pix_in.sink), .pix_out(pix_out.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Shadow of the config registers used by the predictor
  logic [1:0] red_pos, green_pos, blue_pos, alpha_pos;
  logic       unpremul_on;

  pixel_t inverted_q[$];
  int     errors = 0;
  bit     hold_sink = 1'b0;     // long receiver stall requested
  bit     sink_random = 1'b1;

  // Convert a channel byte to a fraction
  function automatic longint chan_frac(longint c);
    return (c << FB) / 255;
  endfunction

  function automatic longint frac_chan(longint v);
    longint r;
    if (v < 0) v = 0;
    if (v > ONE) v = ONE;
    r = (v * 255) / ONE;
    return (r > 255) ? 255 : r;
  endfunction

  function automatic longint hue_level(longint p, longint q, longint t);
    if (t < 0) t += ONE;
    if (t > ONE) t -= ONE;
    if (t < SIXTH) return p + ((q - p) * 6 * t) / ONE;
    if (t < HALF) return q;
    if (t < TWO_THIRDS) return p + ((q - p) * (TWO_THIRDS - t) * 6) / ONE;
    return p;
  endfunction

  // Signed (x-y)/d term, truncated toward zero
  function automatic longint hue_term(longint x, longint y, longint d);
    longint xf, yf;
    xf = chan_frac(x);
    yf = chan_frac(y);
    if (xf >= yf) return ((xf - yf) * ONE) / d;
    return -(((yf - xf) * ONE) / d);
  endfunction

  function automatic pixel_t invert_lightness(pixel_t px);
    longint r, g, b, a, mx, mn, maxf, minf, l, nl, s, h, d, den, q, p;
    longint ro, go, bo;
    pix_byte_t res[4];
    pixel_t o;
    b = px.b0; g = px.b1; r = px.b2; a = px.b3;
    s = 0; h = 0;
    if (unpremul_on && a != 0) begin
      r = (r * 255) / a; if (r > 255) r = 255;
      g = (g * 255) / a; if (g > 255) g = 255;
      b = (b * 255) / a; if (b > 255) b = 255;
    end
    mx = (r > g) ? r : g; if (b > mx) mx = b;
    mn = (r < g) ? r : g; if (b < mn) mn = b;
    maxf = chan_frac(mx);
    minf = chan_frac(mn);
    l = (maxf + minf) / 2;
    if (mx != mn) begin
      d = maxf - minf;
      den = (l > HALF) ? (2 * ONE - maxf - minf) : (maxf + minf);
      s = (den > 0) ? (d * ONE) / den : 0;
      if (r == mx) begin
        h = hue_term(g, b, d);
        if (chan_frac(g) < chan_frac(b)) h += 6 * ONE;
      end else if (g == mx) begin
        h = hue_term(b, r, d) + 2 * ONE;
      end else begin
        h = hue_term(r, g, d) + 4 * ONE;
      end
      if (h < 0) h = 0;
      h /= 6;
    end
    nl = ONE - l;
    if (s == 0) begin
      ro = frac_chan(nl); go = ro; bo = ro;
    end else begin
      if (nl < HALF) q = (nl * (ONE + s)) / ONE;
      else q = nl + s - (nl * s) / ONE;
      p = 2 * nl - q;
      if (q > ONE) q = ONE;
      if (q < 0) q = 0;
      if (p < 0) p = 0;
      if (p > q) p = q;
      ro = frac_chan(hue_level(p, q, h + THIRD));
      go = frac_chan(hue_level(p, q, h));
      bo = frac_chan(hue_level(p, q, h - THIRD));
    end
    // Flip dark greys
    if (ro == go && ro == bo && ro < DARK_LIMIT) begin
      ro = 255 - ro; go = 255 - go; bo = 255 - bo;
    end
    res[0] = px.b0; res[1] = px.b1; res[2] = px.b2; res[3] = px.b3;
    res[alpha_pos] = px.b3;
    res[red_pos] = ro[7:0];
    res[green_pos] = go[7:0];
    res[blue_pos] = bo[7:0];
    o.b0 = res[0]; o.b1 = res[1]; o.b2 = res[2]; o.b3 = res[3];
    return o;
  endfunction

  // APB write: setup then access, completes when pready is seen
  task automatic reg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_RED_SLOT:   red_pos = val[1:0];
      REG_GREEN_SLOT: green_pos = val[1:0];
      REG_BLUE_SLOT:  blue_pos = val[1:0];
      REG_ALPHA_SLOT: alpha_pos = val[1:0];
      REG_UNPREMUL:   unpremul_on = val[0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [1:0] rp, logic [1:0] gp, logic [1:0] bp, logic [1:0] ap,
                         logic un);
    reg_write(REG_RED_SLOT, CFG_DATA_W'(rp));
    reg_write(REG_GREEN_SLOT, CFG_DATA_W'(gp));
    reg_write(REG_BLUE_SLOT, CFG_DATA_W'(bp));
    reg_write(REG_ALPHA_SLOT, CFG_DATA_W'(ap));
    reg_write(REG_UNPREMUL, CFG_DATA_W'(un));
  endtask

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one word and hold it until it is taken; valid stays high when the
  // next word follows with no gap
  task automatic send_word(pixel_t px, bit fixed, pixel_t want, bit gaps);
    int n;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      pix_in.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.in_byte0 <= px.b0; pix_in.in_byte1 <= px.b1;
    pix_in.in_byte2 <= px.b2; pix_in.in_byte3 <= px.b3;
    do @(posedge clk); while (!pix_in.ready);
    if (fixed) inverted_q.push_back(want);
    else inverted_q.push_back(invert_lightness(px));
  endtask

  // Drop valid and wait for the pipeline to drain before touching registers
  task automatic drain();
    pix_in.valid <= 1'b0;
    while (inverted_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    int k;
    p = pixel_t'($urandom);
    k = $urandom_range(0, 9);
    if (k == 0) begin           // grey
      p.b1 = p.b0; p.b2 = p.b0;
    end else if (k == 1) begin  // premultiplied: channels within alpha
      p.b0 = 8'($urandom_range(0, p.b3)); p.b1 = 8'($urandom_range(0, p.b3));
      p.b2 = 8'($urandom_range(0, p.b3));
    end else if (k == 2) begin  // zero or full alpha
      p.b3 = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
    end else if (k == 3) begin  // two channels tie
      p.b1 = p.b2;
    end
    return p;
  endfunction

  // Receiver: random stalls, with one long hold on request
  initial begin
    int n;
    pix_out.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_sink) begin
        pix_out.ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_sink = 1'b0;
      end else if (sink_random && $urandom_range(0, 3) == 0) begin
        pix_out.ready <= 1'b0;
        n = gap_len() + 1;
        repeat (n) @(posedge clk);
      end else begin
        pix_out.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare every taken result with the oldest expected word
  always @(posedge clk) begin
    pixel_t w;
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (inverted_q.size() == 0) begin
        $error("unexpected word %h%h%h%h", pix_out.out_byte3, pix_out.out_byte2,
               pix_out.out_byte1, pix_out.out_byte0);
        errors++;
      end else begin
        w = inverted_q.pop_front();
        if (pix_out.out_byte0 !== w.b0) begin
          $error("out_byte0 expected %0d actual %0d", w.b0, pix_out.out_byte0); errors++;
        end
        if (pix_out.out_byte1 !== w.b1) begin
          $error("out_byte1 expected %0d actual %0d", w.b1, pix_out.out_byte1); errors++;
        end
        if (pix_out.out_byte2 !== w.b2) begin
          $error("out_byte2 expected %0d actual %0d", w.b2, pix_out.out_byte2); errors++;
        end
        if (pix_out.out_byte3 !== w.b3) begin
          $error("out_byte3 expected %0d actual %0d", w.b3, pix_out.out_byte3); errors++;
        end
      end
    end
  end

  // Hard limit on run length
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  stim_row_t dir_rows[$];

  initial begin
    stim_row_t row;
    pixel_t px;
    pix_in.valid = 1'b0;
    pix_in.in_byte0 = '0; pix_in.in_byte1 = '0;
    pix_in.in_byte2 = '0; pix_in.in_byte3 = '0;
    red_pos = RED_SLOT_RST; green_pos = GREEN_SLOT_RST;
    blue_pos = BLUE_SLOT_RST; alpha_pos = ALPHA_SLOT_RST;
    unpremul_on = UNPREMUL_RST;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: black and white map to white; mid grey turns into 127,
    // which is a dark grey and flips back to 128
    dir_rows.push_back('{32'h00000000, 1'b1, 32'h00FFFFFF});
    dir_rows.push_back('{32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF});
    dir_rows.push_back('{32'h80000000, 1'b1, 32'h80FFFFFF});
    dir_rows.push_back('{32'h7F808080, 1'b1, 32'h7F808080});
    dir_rows.push_back('{32'hFFFF0000, 1'b0, '0});  // pure red
    dir_rows.push_back('{32'hFF00FF00, 1'b0, '0});  // pure green
    dir_rows.push_back('{32'hFF0000FF, 1'b0, '0});  // pure blue
    dir_rows.push_back('{32'h40FF00FF, 1'b0, '0});  // red max, green below blue
    dir_rows.push_back('{32'h10FEFF01, 1'b0, '0});  // green max, red just below, blue near zero
    dir_rows.push_back('{32'hAA010000, 1'b0, '0});  // dark red, full saturation
    dir_rows.push_back('{32'h55FFFE00, 1'b0, '0});
    dir_rows.push_back('{32'hC3123456, 1'b0, '0});
    dir_rows.push_back('{32'h017F807F, 1'b0, '0});
    foreach (dir_rows[i])
      send_word(dir_rows[i].pix, dir_rows[i].fixed, dir_rows[i].want, 1'b0);
    drain();

    // Un-premultiply: zero alpha, channels above alpha saturate, normal
    set_all(2'd2, 2'd1, 2'd0, 2'd3, 1'b1);
    send_word(32'h00405060, 1'b0, '0, 1'b0);
    send_word(32'h10FF2008, 1'b0, '0, 1'b0);
    send_word(32'h80402010, 1'b0, '0, 1'b0);
    send_word(32'hFF112233, 1'b0, '0, 1'b0);
    drain();
    // Slot collisions: all on slot 0 (blue wins), then all on slot 3
    set_all(2'd0, 2'd0, 2'd0, 2'd0, 1'b0);
    send_word(32'h12345678, 1'b0, '0, 1'b0);
    send_word(32'hFF00FF80, 1'b0, '0, 1'b0);
    drain();
    set_all(2'd3, 2'd3, 2'd3, 2'd3, 1'b1);
    send_word(32'h80FF0040, 1'b0, '0, 1'b0);
    drain();

    // Random phases with varied settings; the first includes a long sink hold
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) set_all(2'd2, 2'd1, 2'd0, 2'd3, 1'b0);
      else set_all(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                   2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)));
      for (int k = 0; k < 158; k++) begin
        if (ph == 0 && k == 10) hold_sink = 1'b1;
        px = rand_pixel();
        // back-to-back stretches without gaps too
        send_word(px, 1'b0, '0, (ph % 2 == 1) ? 1'b0 : 1'b1);
      end
      drain();
    end

    if (errors == 0 && inverted_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
